@@ rtl/human_time_expression_parser_macros.svh @@
// Assertion macros for the time expression parser.
`ifndef HUMAN_TIME_EXPRESSION_PARSER_MACROS_SVH
`define HUMAN_TIME_EXPRESSION_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define HTE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define HTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/hte_pkg.sv @@
// Shared types, unit tables and constants of the time expression parser.
`default_nettype none

package hte_pkg;

  localparam int UNIT_COUNT          = 22;
  localparam int UNIT_MAX_LEN        = 7;
  localparam int QUEUE_DEPTH_DEFAULT = 2;
  localparam int MULT_W              = 46;

  localparam logic [63:0] SEC_CEIL = 64'd30000000000;
  localparam logic [63:0] MS_CEIL  = 64'd30000000000000;

  localparam logic [MULT_W-1:0] US_ONE    = 46'd1;
  localparam logic [MULT_W-1:0] US_MILLI  = 46'd1000;
  localparam logic [MULT_W-1:0] US_SECOND = 46'd1000000;
  localparam logic [MULT_W-1:0] US_MINUTE = 46'd60000000;
  localparam logic [MULT_W-1:0] US_HOUR   = 46'd3600000000;
  localparam logic [MULT_W-1:0] US_DAY    = 46'd86400000000;
  localparam logic [MULT_W-1:0] US_WEEK   = 46'd604800000000;
  localparam logic [MULT_W-1:0] US_YEAR   = 46'd31536000000000;

  localparam logic [2:0] FORM_NOW   = 3'd0;
  localparam logic [2:0] FORM_REL   = 3'd1;
  localparam logic [2:0] FORM_SEC   = 3'd2;
  localparam logic [2:0] FORM_MILLI = 3'd3;
  localparam logic [2:0] FORM_MICRO = 3'd4;

  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_N     = 8'h6e;
  localparam logic [7:0] CHAR_O     = 8'h6f;
  localparam logic [7:0] CHAR_W     = 8'h77;

  localparam logic [2:0] UNIT_LEN [UNIT_COUNT] = '{
    3'd1, 3'd3, 3'd4, 3'd6, 3'd7,
    3'd1, 3'd3, 3'd4, 3'd6, 3'd7,
    3'd1, 3'd4, 3'd5,
    3'd1, 3'd3, 3'd4,
    3'd1, 3'd4, 3'd5,
    3'd1, 3'd4, 3'd5
  };

  // Left-justified, space padded; bytes past the word length never decide a match.
  localparam logic [8*UNIT_MAX_LEN-1:0] UNIT_WORD [UNIT_COUNT] = '{
    "s      ", "sec    ", "secs   ", "second ", "seconds",
    "m      ", "min    ", "mins   ", "minute ", "minutes",
    "h      ", "hour   ", "hours  ",
    "d      ", "day    ", "days   ",
    "w      ", "week   ", "weeks  ",
    "y      ", "year   ", "years  "
  };

  localparam logic [MULT_W-1:0] UNIT_MICROS [UNIT_COUNT] = '{
    US_SECOND, US_SECOND, US_SECOND, US_SECOND, US_SECOND,
    US_MINUTE, US_MINUTE, US_MINUTE, US_MINUTE, US_MINUTE,
    US_HOUR, US_HOUR, US_HOUR,
    US_DAY, US_DAY, US_DAY,
    US_WEEK, US_WEEK, US_WEEK,
    US_YEAR, US_YEAR, US_YEAR
  };

  typedef struct packed {
    logic                  now_hit;
    logic                  rel_ok;
    logic                  digits_ok;
    logic [UNIT_COUNT-1:0] cand;
    logic [2:0]            suffix_len;
    logic [63:0]           accum;
    logic [63:0]           now_us;
  } hte_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } hte_qstat_t;

endpackage

`default_nettype wire

@@ rtl/hte_front.sv @@
// Character scanner: per-character parse state and job build at the last character.
`default_nettype none

module hte_front import hte_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  ch,
  input  logic        last,
  input  logic [63:0] now_us,
  output logic        push,
  output hte_job_t    job
);

  logic [2:0]            char_index, char_index_next;
  logic                  leading_minus, leading_minus_next;
  logic                  in_suffix, in_suffix_next;
  logic                  all_digits, all_digits_next;
  logic [63:0]           digit_accum, digit_accum_next;
  logic                  digit_overflow, digit_overflow_next;
  logic                  now_match, now_match_next;
  logic [UNIT_COUNT-1:0] unit_candidates, unit_candidates_next;
  logic [2:0]            suffix_length, suffix_length_next;

  logic                  digit;
  logic [7:0]            now_char;
  logic [67:0]           accum_wide;
  logic [UNIT_COUNT-1:0] char_hit;

  always_comb begin
    digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    case (char_index)
      3'd0:    now_char = CHAR_N;
      3'd1:    now_char = CHAR_O;
      3'd2:    now_char = CHAR_W;
      default: now_char = CHAR_N;
    endcase
    accum_wide = ({4'd0, digit_accum} << 3) + ({4'd0, digit_accum} << 1)
               + {64'd0, ch[3:0]};

    for (int k = 0; k < UNIT_COUNT; k++) begin
      char_hit[k] = 1'b0;
      for (int j = 0; j < UNIT_MAX_LEN; j++) begin
        if (suffix_length == 3'(j) &&
            ch == UNIT_WORD[k][8*(UNIT_MAX_LEN-1-j) +: 8]) begin
          char_hit[k] = 1'b1;
        end
      end
    end

    now_match_next       = now_match && (char_index < 3'd3) && (ch == now_char);
    all_digits_next      = all_digits && digit;
    char_index_next      = (char_index == 3'd7) ? char_index : char_index + 3'd1;
    leading_minus_next   = leading_minus;
    in_suffix_next       = in_suffix;
    digit_accum_next     = digit_accum;
    digit_overflow_next  = digit_overflow;
    unit_candidates_next = unit_candidates;
    suffix_length_next   = suffix_length;

    if (char_index == 3'd1 && !digit) begin
      leading_minus_next = 1'b0;
    end

    if (char_index == 3'd0 && ch == CHAR_MINUS) begin
      leading_minus_next = 1'b1;
    end else if (digit && !in_suffix) begin
      digit_accum_next    = accum_wide[63:0];
      digit_overflow_next = digit_overflow || (accum_wide[67:64] != 4'd0);
    end else begin
      in_suffix_next = 1'b1;
      if (suffix_length == 3'd7) begin
        unit_candidates_next = '0;
      end else begin
        for (int k = 0; k < UNIT_COUNT; k++) begin
          if (suffix_length >= UNIT_LEN[k] || !char_hit[k]) begin
            unit_candidates_next[k] = 1'b0;
          end
        end
        suffix_length_next = suffix_length + 3'd1;
      end
    end
  end

  assign push          = take && last;
  assign job.now_hit   = now_match_next && (char_index_next == 3'd3);
  assign job.rel_ok    = leading_minus_next && (char_index_next >= 3'd2) && !digit_overflow_next;
  assign job.digits_ok = all_digits_next && !digit_overflow_next;
  assign job.cand       = unit_candidates_next;
  assign job.suffix_len = suffix_length_next;
  assign job.accum      = digit_accum_next;
  assign job.now_us     = now_us;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      char_index      <= 3'd0;
      leading_minus   <= 1'b0;
      in_suffix       <= 1'b0;
      all_digits      <= 1'b1;
      digit_accum     <= 64'd0;
      digit_overflow  <= 1'b0;
      now_match       <= 1'b1;
      unit_candidates <= '1;
      suffix_length   <= 3'd0;
    end else if (take) begin
      char_index      <= char_index_next;
      leading_minus   <= leading_minus_next;
      in_suffix       <= in_suffix_next;
      all_digits      <= all_digits_next;
      digit_accum     <= digit_accum_next;
      digit_overflow  <= digit_overflow_next;
      now_match       <= now_match_next;
      unit_candidates <= unit_candidates_next;
      suffix_length   <= suffix_length_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/hte_queue.sv @@
// Job queue between the character scanner and the result pipeline.
`default_nettype none

module hte_queue import hte_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  hte_job_t   wr_job,
  input  logic       pop,
  output hte_job_t   rd_job,
  output hte_qstat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hte_job_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign rd_job     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/hte_back.sv @@
// Result pipeline: classify, split multiply, sum, subtract and output register.
`default_nettype none

module hte_back import hte_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  input  hte_job_t    job,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [63:0] time_us,
  output logic [2:0]  form
);

  logic adv;

  logic              unit_hit;
  logic [MULT_W-1:0] unit_m;
  logic              c_found;
  logic [2:0]        c_form;
  logic              c_sub;
  logic [MULT_W-1:0] c_m;

  logic              s1_valid, s1_found, s1_sub;
  logic [2:0]        s1_form;
  logic [63:0]       s1_a, s1_now;
  logic [MULT_W-1:0] s1_m;

  logic              s2_valid, s2_found, s2_sub;
  logic [2:0]        s2_form;
  logic [63:0]       s2_p0, s2_now;
  logic [31:0]       s2_p1, s2_p2;

  logic              s3_valid, s3_found, s3_sub;
  logic [2:0]        s3_form;
  logic [63:0]       s3_prod, s3_now;

  logic [63:0]       p0_c;
  logic [31:0]       p1_c, p2_c, mid_c;

  assign adv = !out_valid || out_ready;
  assign pop = adv && job_valid;

  always_comb begin
    unit_hit = 1'b0;
    unit_m   = '0;
    for (int k = UNIT_COUNT - 1; k >= 0; k--) begin
      if (job.cand[k] && job.suffix_len == UNIT_LEN[k]) begin
        unit_hit = 1'b1;
        unit_m   = UNIT_MICROS[k];
      end
    end

    c_found = 1'b0;
    c_form  = FORM_NOW;
    c_sub   = 1'b0;
    c_m     = '0;
    if (job.now_hit) begin
      c_found = 1'b1;
      c_form  = FORM_NOW;
      c_sub   = 1'b1;
    end else if (job.rel_ok && unit_hit) begin
      c_found = 1'b1;
      c_form  = FORM_REL;
      c_sub   = 1'b1;
      c_m     = unit_m;
    end else if (job.digits_ok) begin
      if (job.accum < SEC_CEIL) begin
        c_found = 1'b1;
        c_form  = FORM_SEC;
        c_m     = US_SECOND;
      end else if (job.accum > SEC_CEIL && job.accum < MS_CEIL) begin
        c_found = 1'b1;
        c_form  = FORM_MILLI;
        c_m     = US_MILLI;
      end else if (job.accum > MS_CEIL) begin
        c_found = 1'b1;
        c_form  = FORM_MICRO;
        c_m     = US_ONE;
      end
    end
  end

  always_comb begin
    p0_c  = {32'd0, s1_a[31:0]} * {32'd0, s1_m[31:0]};
    p1_c  = s1_a[63:32] * s1_m[31:0];
    p2_c  = s1_a[31:0] * {{(64 - MULT_W){1'b0}}, s1_m[MULT_W-1:32]};
    mid_c = s2_p1 + s2_p2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= job_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_found <= c_found;
      s1_form  <= c_form;
      s1_sub   <= c_sub;
      s1_a     <= job.accum;
      s1_m     <= c_m;
      s1_now   <= job.now_us;

      s2_found <= s1_found;
      s2_form  <= s1_form;
      s2_sub   <= s1_sub;
      s2_p0    <= p0_c;
      s2_p1    <= p1_c;
      s2_p2    <= p2_c;
      s2_now   <= s1_now;

      s3_found <= s2_found;
      s3_form  <= s2_form;
      s3_sub   <= s2_sub;
      s3_prod  <= s2_p0 + {mid_c, 32'd0};
      s3_now   <= s2_now;

      found    <= s3_found;
      form     <= s3_found ? s3_form : FORM_NOW;
      time_us  <= !s3_found ? 64'd0 : (s3_sub ? s3_now - s3_prod : s3_prod);
    end
  end

endmodule

`default_nettype wire

@@ rtl/human_time_expression_parser.sv @@
// Top level of the time expression parser: scanner, job queue and result pipeline.
`default_nettype none

// Takes one character per cycle; every character, last or not, is accepted in the cycle it
// arrives while the job queue has room. The character carrying last closes the expression and
// queues a job; its result passes the queue, the s1, s2 and s3 registers and the output
// register, and while out_ready stays high the sustained rate is one result per cycle. The
// result pipeline splits the duration multiply into 32-bit partial products over two stages.
// in_ready falls only when QUEUE_DEPTH jobs wait, behind a stalled output if QUEUE_DEPTH > 1.

`include "human_time_expression_parser_macros.svh"

module human_time_expression_parser import hte_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        last,
  input  logic [63:0] now_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [63:0] time_us,
  output logic [2:0]  form
);

  logic       take;
  logic       push;
  logic       pop;
  hte_job_t   wr_job;
  hte_job_t   rd_job;
  hte_qstat_t qstat;

  assign in_ready = !qstat.full;
  assign take     = in_valid && in_ready;

  hte_front u_front (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .ch     (ch),
    .last   (last),
    .now_us (now_us),
    .push   (push),
    .job    (wr_job)
  );

  hte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .stat   (qstat)
  );

  hte_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!qstat.empty),
    .job       (rd_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found     (found),
    .time_us   (time_us),
    .form      (form)
  );

  `HTE_ASSERT_NEXT(a_push_fills_queue, take && last, !qstat.empty, "queued job missing")
  `HTE_ASSERT_IMPL(a_miss_is_zero, out_valid && !found, time_us == 64'd0 && form == FORM_NOW, "miss not zero")
  `HTE_ASSERT_IMPL(a_form_range, out_valid && found, form <= FORM_MICRO, "form out of range")

endmodule

`default_nettype wire
